>>> sv/sgse_pkg.sv
// Shared types, codes and widths of the scaled gradient step engine.
package sgse_pkg;

    localparam int INDEX_W    = 10;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 48;
    localparam int PCNT_W     = 11;
    localparam int ROWS_CFG_W = 4;
    localparam int ROWS_W     = 7;
    localparam int CFG_W      = 3;
    localparam int DIV_NW     = 48;
    localparam int DIV_DW     = 65;
    localparam int PROD_W     = 66;

    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;

    // input item operations
    localparam logic [1:0] FUNC_LOAD_PARAM = 2'd0;
    localparam logic [1:0] FUNC_GRADIENT   = 2'd1;
    localparam logic [1:0] FUNC_LOAD_SCHED = 2'd2;
    localparam logic [1:0] FUNC_NONE       = 2'd3;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_START_RATE      = 3'd0;
    localparam logic [CFG_W-1:0] CFG_DECAY_CONSTANT  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_EVALUATE_EVERY  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_EVALUATE_DURING = 3'd3;
    localparam logic [CFG_W-1:0] CFG_EPSILON_OFFSET  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_PARAM_COUNT     = 3'd5;
    localparam logic [CFG_W-1:0] CFG_SCHEDULE_ROWS   = 3'd6;

    // multiplier operand selection
    localparam logic [1:0] MUL_SCHED = 2'd0;
    localparam logic [1:0] MUL_DECAY = 2'd1;
    localparam logic [1:0] MUL_T     = 2'd2;
    localparam logic [1:0] MUL_U     = 2'd3;

    // divider operand selection
    localparam logic [1:0] DIV_DECAY = 2'd0;
    localparam logic [1:0] DIV_MOD   = 2'd1;
    localparam logic [1:0] DIV_MEAN  = 2'd2;
    localparam logic [1:0] DIV_RECIP = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       param_wr;
        logic       sched_wr;
        logic       pos_clamp;
        logic       pos_inc;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       rate_sched;
        logic       rate_div;
        logic       div_start;
        logic [1:0] div_sel;
        logic       win_open;
        logic       stage_opened;
        logic       sweep_rst;
        logic       sweep_clr;
        logic       upd_read;
        logic       t_load;
        logic       upd_write;
        logic       rec_read;
        logic       scale_one_wr;
        logic       scale_sat_wr;
        logic       scale_quo_wr;
        logic       rec_next;
        logic       rec_finish;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       stage_open;
        logic       rows_zero;
        logic       sched_adv;
        logic       every_zero;
        logic       div_done;
        logic       rem_zero;
        logic       win_active;
        logic       win_last;
        logic       stage_end;
        logic       eps_neg;
        logic       den_zero;
        logic       sweep_last;
    } status_t;

endpackage

>>> sv/scaled_gradient_step_engine.sv
// Top level of the scaled gradient step engine.
// Applies one gradient element per beat to a store of MAX_PARAMS signed Q16.16
// parameters (param -= rate * grad * scale[i]) and returns the new value, the
// rate in force and stage/window flags. Items are handled one at a time by a
// controller stepping a datapath that owns a single 33x33 multiplier and a
// shared restoring divider retiring one quotient bit per cycle. A parameter
// load or schedule row load is written and its result loaded into the output
// register; a gradient element inside an open stage reads its parameter, sum
// and scale, forms rate * grad, saturates it, multiplies it by the scale and
// writes back. The element that opens a stage first sets the rate, from the
// schedule row reached by stepping past rows or from the decay formula by a
// division, then, when evaluate_every is non-zero, checks with a division
// whether a window opens. When a window opens, the whole sums store is
// cleared, one entry at a time. When a window closes, every scale is
// recomputed, one entry at a time: set to one with a negative epsilon_offset,
// otherwise by two divisions (one when the mean plus epsilon is zero). A
// result waits in the output register while the next beat is accepted; the
// block takes no new beat until the current one has been handed to that
// register. Configuration writes act at once and are meant for idle periods
// only.
module scaled_gradient_step_engine #(
    parameter int MAX_PARAMS  = 1024,
    parameter int SCHED_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sgse_pkg::CFG_W-1:0]           cfg_index,
    input  logic [sgse_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic [sgse_pkg::INDEX_W-1:0]         index,
    input  logic signed [sgse_pkg::DATA_W-1:0]   value,
    input  logic [sgse_pkg::DATA_W-1:0]          factor,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sgse_pkg::INDEX_W-1:0]         out_index,
    output logic signed [sgse_pkg::DATA_W-1:0]   param_value,
    output logic [sgse_pkg::DATA_W-1:0]          rate_now,
    output logic                                 stage_done,
    output logic                                 scales_updated
);
    // commands flow controller to datapath, status flows back
    sgse_pkg::cmd_t    cmd;
    sgse_pkg::status_t status;

    sgse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sgse_dpath #(
        .MAX_PARAMS  (MAX_PARAMS),
        .SCHED_DEPTH (SCHED_DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_func        (func),
        .in_index       (index),
        .in_value       (value),
        .in_factor      (factor),
        .cmd            (cmd),
        .status         (status),
        .out_index      (out_index),
        .param_value    (param_value),
        .rate_now       (rate_now),
        .stage_done     (stage_done),
        .scales_updated (scales_updated)
    );

endmodule

>>> sv/sgse_div.sv
// Restoring divider, one quotient bit per cycle.
module sgse_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sgse_pkg::DIV_NW-1:0]   num,
    input  logic [sgse_pkg::DIV_DW-1:0]   den,
    output logic                          busy,
    output logic                          done,
    output logic [sgse_pkg::DIV_NW-1:0]   quo,
    output logic [sgse_pkg::DIV_DW-1:0]   rem
);
    localparam int NW    = sgse_pkg::DIV_NW;
    localparam int DW    = sgse_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] step_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= CNT_W'(NW - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

>>> sv/sgse_ctrl.sv
// Sequencing state machine of the scaled gradient step engine.
module sgse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sgse_pkg::status_t status,
    output sgse_pkg::cmd_t    cmd
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DISP  = 5'd1;
    localparam logic [4:0] ST_OPEN  = 5'd2;
    localparam logic [4:0] ST_SADV  = 5'd3;
    localparam logic [4:0] ST_SMUL  = 5'd4;
    localparam logic [4:0] ST_SRATE = 5'd5;
    localparam logic [4:0] ST_DMUL  = 5'd6;
    localparam logic [4:0] ST_DDIV  = 5'd7;
    localparam logic [4:0] ST_DWAIT = 5'd8;
    localparam logic [4:0] ST_WIN   = 5'd9;
    localparam logic [4:0] ST_WWAIT = 5'd10;
    localparam logic [4:0] ST_CLR   = 5'd11;
    localparam logic [4:0] ST_URD   = 5'd12;
    localparam logic [4:0] ST_UT    = 5'd13;
    localparam logic [4:0] ST_UU    = 5'd14;
    localparam logic [4:0] ST_UP    = 5'd15;
    localparam logic [4:0] ST_RRD   = 5'd16;
    localparam logic [4:0] ST_REVAL = 5'd17;
    localparam logic [4:0] ST_RW1   = 5'd18;
    localparam logic [4:0] ST_RREC  = 5'd19;
    localparam logic [4:0] ST_RW2   = 5'd20;
    localparam logic [4:0] ST_FIN   = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                unique case (status.func)
                    sgse_pkg::FUNC_LOAD_PARAM:
                    begin
                        cmd.param_wr = 1'b1;
                        state_next   = ST_FIN;
                    end
                    sgse_pkg::FUNC_GRADIENT:
                        state_next = status.stage_open ? ST_URD : ST_OPEN;
                    sgse_pkg::FUNC_LOAD_SCHED:
                    begin
                        cmd.sched_wr = 1'b1;
                        state_next   = ST_FIN;
                    end
                    sgse_pkg::FUNC_NONE:
                        state_next = ST_IDLE;
                endcase
            end
            ST_OPEN:
            begin
                cmd.pos_clamp = 1'b1;
                state_next    = status.rows_zero ? ST_DMUL : ST_SADV;
            end
            ST_SADV:
            begin
                if (status.sched_adv)
                    cmd.pos_inc = 1'b1;
                else
                    state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sgse_pkg::MUL_SCHED;
                state_next  = ST_SRATE;
            end
            ST_SRATE:
            begin
                cmd.rate_sched = 1'b1;
                state_next     = ST_WIN;
            end
            ST_DMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sgse_pkg::MUL_DECAY;
                state_next  = ST_DDIV;
            end
            ST_DDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sgse_pkg::DIV_DECAY;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.rate_div = 1'b1;
                    state_next   = ST_WIN;
                end
            end
            ST_WIN:
            begin
                if (status.every_zero)
                begin
                    cmd.stage_opened = 1'b1;
                    state_next       = ST_URD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sgse_pkg::DIV_MOD;
                    state_next    = ST_WWAIT;
                end
            end
            ST_WWAIT:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.win_open  = 1'b1;
                        cmd.sweep_rst = 1'b1;
                        state_next    = ST_CLR;
                    end
                    else
                    begin
                        cmd.stage_opened = 1'b1;
                        state_next       = ST_URD;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.sweep_clr = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.stage_opened = 1'b1;
                    state_next       = ST_URD;
                end
            end
            ST_URD:
            begin
                cmd.upd_read = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = sgse_pkg::MUL_T;
                state_next   = ST_UT;
            end
            ST_UT:
            begin
                cmd.t_load = 1'b1;
                state_next = ST_UU;
            end
            ST_UU:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sgse_pkg::MUL_U;
                state_next  = ST_UP;
            end
            ST_UP:
            begin
                cmd.upd_write = 1'b1;
                if (status.stage_end && status.win_active && status.win_last)
                begin
                    cmd.sweep_rst = 1'b1;
                    state_next    = ST_RRD;
                end
                else
                    state_next = ST_FIN;
            end
            ST_RRD:
            begin
                cmd.rec_read = 1'b1;
                state_next   = ST_REVAL;
            end
            ST_REVAL:
            begin
                if (status.eps_neg)
                begin
                    cmd.scale_one_wr = 1'b1;
                    cmd.rec_next     = !status.sweep_last;
                    cmd.rec_finish   = status.sweep_last;
                    state_next       = status.sweep_last ? ST_FIN : ST_RRD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sgse_pkg::DIV_MEAN;
                    state_next    = ST_RW1;
                end
            end
            ST_RW1:
            begin
                if (status.div_done)
                    state_next = ST_RREC;
            end
            ST_RREC:
            begin
                if (status.den_zero)
                begin
                    cmd.scale_sat_wr = 1'b1;
                    cmd.rec_next     = !status.sweep_last;
                    cmd.rec_finish   = status.sweep_last;
                    state_next       = status.sweep_last ? ST_FIN : ST_RRD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sgse_pkg::DIV_RECIP;
                    state_next    = ST_RW2;
                end
            end
            ST_RW2:
            begin
                if (status.div_done)
                begin
                    cmd.scale_quo_wr = 1'b1;
                    cmd.rec_next     = !status.sweep_last;
                    cmd.rec_finish   = status.sweep_last;
                    state_next       = status.sweep_last ? ST_FIN : ST_RRD;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still pending");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DISP))
        else $error("accepted beat not dispatched");

endmodule

>>> sv/sgse_dpath.sv
// Datapath: configuration, stores, multiplier, divider and result register.
module sgse_dpath #(
    parameter int MAX_PARAMS  = 1024,
    parameter int SCHED_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sgse_pkg::CFG_W-1:0]           cfg_index,
    input  logic [sgse_pkg::DATA_W-1:0]          cfg_data,
    input  logic [1:0]                           in_func,
    input  logic [sgse_pkg::INDEX_W-1:0]         in_index,
    input  logic signed [sgse_pkg::DATA_W-1:0]   in_value,
    input  logic [sgse_pkg::DATA_W-1:0]          in_factor,
    input  sgse_pkg::cmd_t                       cmd,
    output sgse_pkg::status_t                    status,
    output logic [sgse_pkg::INDEX_W-1:0]         out_index,
    output logic signed [sgse_pkg::DATA_W-1:0]   param_value,
    output logic [sgse_pkg::DATA_W-1:0]          rate_now,
    output logic                                 stage_done,
    output logic                                 scales_updated
);
    localparam int DW  = sgse_pkg::DATA_W;
    localparam int SW  = sgse_pkg::SUM_W;
    localparam int IW  = sgse_pkg::INDEX_W;
    localparam int RW  = sgse_pkg::ROWS_W;
    localparam int PW  = sgse_pkg::PROD_W;
    localparam int AW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int SPW = (SCHED_DEPTH > 1) ? $clog2(SCHED_DEPTH) : 1;
    localparam int CW  = ($clog2(MAX_PARAMS + 1) > sgse_pkg::PCNT_W) ?
                         $clog2(MAX_PARAMS + 1) : sgse_pkg::PCNT_W;
    localparam logic [RW-1:0] DEPTH_R = RW'(SCHED_DEPTH);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_PARAMS);
    localparam logic [AW-1:0] LAST_A  = AW'(MAX_PARAMS - 1);

    function automatic logic [DW-1:0] sat_q(input logic signed [PW-1:0] p);
        logic hi_one;
        logic hi_zero;
        hi_one  = &p[PW-2:DW+15];
        hi_zero = ~|p[PW-2:DW+15];
        if (!p[PW-1] && !hi_zero)
            return sgse_pkg::SAT_POS;
        else if (p[PW-1] && !hi_one)
            return ~sgse_pkg::SAT_POS;
        else
            return p[DW+15:16];
    endfunction

    // configuration
    logic [DW-1:0]                   start_rate_reg;
    logic [DW-1:0]                   decay_reg;
    logic [DW-1:0]                   every_reg;
    logic [DW-1:0]                   during_reg;
    logic [DW-1:0]                   eps_reg;
    logic [sgse_pkg::PCNT_W-1:0]     pcount_reg;
    logic [sgse_pkg::ROWS_CFG_W-1:0] rows_reg;

    // item and control state
    logic [1:0]        func_reg;
    logic [IW-1:0]     index_reg;
    logic [AW-1:0]     slot_reg;
    logic [DW-1:0]     value_reg;
    logic [DW-1:0]     factor_reg;
    logic [DW-1:0]     stage_count_reg;
    logic [DW:0]       window_left_reg;
    logic [SPW-1:0]    pos_reg;
    logic [DW-1:0]     rate_reg;
    logic              stage_open_reg;
    logic              scales_valid_reg;
    logic [AW-1:0]     sweep_reg;
    logic [DW-1:0]     res_pval_reg;
    logic              done_flag_reg;
    logic              upd_flag_reg;
    logic signed [PW-1:0] prod_reg;
    logic [DW-1:0]     t_reg;

    logic [DW-1:0] sched_thr_reg [SCHED_DEPTH];
    logic [DW-1:0] sched_fac_reg [SCHED_DEPTH];

    logic [DW-1:0] param_mem [MAX_PARAMS];
    logic [SW-1:0] sum_mem   [MAX_PARAMS];
    logic [DW-1:0] scale_mem [MAX_PARAMS];
    logic [DW-1:0] param_rd_reg;
    logic [SW-1:0] sum_rd_reg;
    logic [DW-1:0] scale_rd_reg;

    logic [DW-1:0] out_index_pad;
    logic [IW-1:0] out_index_reg;
    logic [DW-1:0] out_pval_reg;
    logic [DW-1:0] out_rate_reg;
    logic          out_done_reg;
    logic          out_upd_reg;

    logic [AW-1:0]          slot_in;
    logic [RW-1:0]          rows_eff;
    logic [RW-1:0]          pos_x;
    logic [DW-1:0]          thr_now;
    logic [CW-1:0]          pc_x;
    logic [CW-1:0]          cnt_eff;
    logic signed [DW:0]     mul_a;
    logic signed [DW:0]     mul_b;
    logic [DW-1:0]          scale_eff;
    logic [DW-1:0]          u_val;
    logic signed [DW:0]     p_diff;
    logic [DW-1:0]          p_new;
    logic [DW:0]            abs_g;
    logic [SW:0]            sum_add;
    logic [SW-1:0]          sum_new;
    logic [SW:0]            recip_den;
    logic [DW-1:0]          quo_sat;
    logic [AW-1:0]          sum_addr;
    logic                   sum_we;
    logic [SW-1:0]          sum_wdata;
    logic                   scale_we;
    logic [DW-1:0]          scale_wdata;
    logic                   win_active;

    logic                          div_start;
    logic [sgse_pkg::DIV_NW-1:0]   div_num;
    logic [sgse_pkg::DIV_DW-1:0]   div_den;
    logic                          div_busy;
    logic                          div_done;
    logic [sgse_pkg::DIV_NW-1:0]   div_quo;
    logic [sgse_pkg::DIV_DW-1:0]   div_rem;

    // store slot: index reduced modulo the store depth
    generate
        if (MAX_PARAMS >= 1024)
        begin : g_slot_direct
            assign slot_in = AW'(in_index);
        end
        else
        begin : g_slot_mod
            logic [IW:0] mod_r;
            always_comb
            begin
                mod_r = '0;
                for (int b = IW - 1; b >= 0; b--)
                begin
                    mod_r = {mod_r[IW-1:0], in_index[b]};
                    if (mod_r >= (IW + 1)'(MAX_PARAMS))
                        mod_r = mod_r - (IW + 1)'(MAX_PARAMS);
                end
            end
            assign slot_in = AW'(mod_r);
        end
    endgenerate

    always_comb
    begin
        rows_eff   = (RW'(rows_reg) > DEPTH_R) ? DEPTH_R : RW'(rows_reg);
        pos_x      = RW'(pos_reg);
        thr_now    = sched_thr_reg[pos_reg];
        pc_x       = CW'(pcount_reg);
        if (pc_x == '0)
            cnt_eff = CW'(1);
        else if (pc_x > MAX_C)
            cnt_eff = MAX_C;
        else
            cnt_eff = pc_x;
        win_active = !window_left_reg[DW] && (window_left_reg != '0);
        scale_eff  = scales_valid_reg ? scale_rd_reg : '0;
        u_val      = sat_q(prod_reg);
        p_diff     = $signed({param_rd_reg[DW-1], param_rd_reg})
                   - $signed({u_val[DW-1], u_val});
        if (p_diff[DW] != p_diff[DW-1])
            p_new = p_diff[DW] ? ~sgse_pkg::SAT_POS : sgse_pkg::SAT_POS;
        else
            p_new = p_diff[DW-1:0];
        abs_g      = value_reg[DW-1] ? ((DW + 1)'(0) - {1'b1, value_reg})
                                     : {1'b0, value_reg};
        sum_add    = {1'b0, sum_rd_reg} + (SW + 1)'(abs_g);
        sum_new    = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
        recip_den  = {1'b0, div_quo} + (SW + 1)'(eps_reg[DW-2:0]);
        quo_sat    = (|div_quo[sgse_pkg::DIV_NW-1:DW-1]) ? sgse_pkg::SAT_POS
                                                         : div_quo[DW-1:0];
    end

    // multiplier operands
    always_comb
    begin
        unique case (cmd.mul_sel)
            sgse_pkg::MUL_SCHED:
            begin
                mul_a = $signed({1'b0, start_rate_reg});
                mul_b = $signed({1'b0, sched_fac_reg[pos_reg]});
            end
            sgse_pkg::MUL_DECAY:
            begin
                mul_a = $signed({1'b0, decay_reg});
                mul_b = $signed({1'b0, stage_count_reg});
            end
            sgse_pkg::MUL_T:
            begin
                mul_a = $signed({1'b0, rate_reg});
                mul_b = $signed({value_reg[DW-1], value_reg});
            end
            sgse_pkg::MUL_U:
            begin
                mul_a = $signed({t_reg[DW-1], t_reg});
                mul_b = $signed({1'b0, scale_eff});
            end
        endcase
    end

    // divider operands
    always_comb
    begin
        div_start = cmd.div_start;
        unique case (cmd.div_sel)
            sgse_pkg::DIV_DECAY:
            begin
                div_num = {start_rate_reg, 16'h0000};
                div_den = {1'b0, prod_reg[2*DW-1:0]} + sgse_pkg::DIV_DW'(sgse_pkg::Q_ONE);
            end
            sgse_pkg::DIV_MOD:
            begin
                div_num = sgse_pkg::DIV_NW'(stage_count_reg);
                div_den = sgse_pkg::DIV_DW'(every_reg);
            end
            sgse_pkg::DIV_MEAN:
            begin
                div_num = sum_rd_reg;
                div_den = sgse_pkg::DIV_DW'(during_reg);
            end
            sgse_pkg::DIV_RECIP:
            begin
                div_num = sgse_pkg::DIV_NW'(64'h1_0000_0000);
                div_den = sgse_pkg::DIV_DW'(recip_den);
            end
        endcase
    end

    sgse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // configuration registers and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rate_reg   <= 32'd655;
            decay_reg        <= '0;
            every_reg        <= 32'd1000;
            during_reg       <= 32'd1000;
            eps_reg          <= 32'd1;
            pcount_reg       <= 11'd1024;
            rows_reg         <= '0;
            pos_reg          <= '0;
            stage_count_reg  <= '0;
            window_left_reg  <= '1;
            rate_reg         <= '0;
            stage_open_reg   <= 1'b0;
            scales_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sgse_pkg::CFG_START_RATE:      start_rate_reg <= cfg_data;
                    sgse_pkg::CFG_DECAY_CONSTANT:  decay_reg      <= cfg_data;
                    sgse_pkg::CFG_EVALUATE_EVERY:  every_reg      <= cfg_data;
                    sgse_pkg::CFG_EVALUATE_DURING: during_reg     <= cfg_data;
                    sgse_pkg::CFG_EPSILON_OFFSET:  eps_reg        <= cfg_data;
                    sgse_pkg::CFG_PARAM_COUNT:
                        pcount_reg <= cfg_data[sgse_pkg::PCNT_W-1:0];
                    sgse_pkg::CFG_SCHEDULE_ROWS:
                        rows_reg <= cfg_data[sgse_pkg::ROWS_CFG_W-1:0];
                    default: ;
                endcase
            end

            priority if ((cfg_write && cfg_index == sgse_pkg::CFG_SCHEDULE_ROWS)
                         || cmd.sched_wr)
                pos_reg <= '0;
            else if (cmd.pos_clamp && (pos_x >= rows_eff))
                pos_reg <= '0;
            else if (cmd.pos_inc)
                pos_reg <= pos_reg + 1'b1;

            if (cmd.rate_sched)
                rate_reg <= (|prod_reg[2*DW-1:DW+16]) ? '1 : prod_reg[DW+15:16];
            else if (cmd.rate_div)
                rate_reg <= div_quo[DW-1:0];

            if (cmd.win_open)
                window_left_reg <= {1'b0, during_reg};
            else if (cmd.upd_write && status.stage_end && win_active)
                window_left_reg <= window_left_reg - 1'b1;

            if (cmd.stage_opened)
                stage_open_reg <= 1'b1;
            else if (cmd.upd_write && status.stage_end)
                stage_open_reg <= 1'b0;

            if (cmd.upd_write && status.stage_end)
                stage_count_reg <= stage_count_reg + 1'b1;

            if (cmd.rec_finish)
                scales_valid_reg <= 1'b1;
        end
    end

    // item latch, arithmetic registers and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg      <= in_func;
            index_reg     <= in_index;
            slot_reg      <= slot_in;
            value_reg     <= in_value;
            factor_reg    <= in_factor;
            res_pval_reg  <= (in_func == sgse_pkg::FUNC_LOAD_PARAM) ? in_value : '0;
            done_flag_reg <= 1'b0;
            upd_flag_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.upd_write)
            begin
                res_pval_reg  <= p_new;
                done_flag_reg <= status.stage_end;
            end
            if (cmd.rec_finish)
                upd_flag_reg <= 1'b1;
        end

        if (cmd.sched_wr && (index_reg < IW'(SCHED_DEPTH)))
        begin
            sched_thr_reg[index_reg[SPW-1:0]] <= value_reg;
            sched_fac_reg[index_reg[SPW-1:0]] <= factor_reg;
        end

        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.t_load)
            t_reg <= sat_q(prod_reg);

        if (cmd.sweep_rst)
            sweep_reg <= '0;
        else if (cmd.sweep_clr || cmd.rec_next)
            sweep_reg <= sweep_reg + 1'b1;

        if (cmd.out_load)
        begin
            out_index_reg <= index_reg;
            out_pval_reg  <= res_pval_reg;
            out_rate_reg  <= rate_reg;
            out_done_reg  <= done_flag_reg;
            out_upd_reg   <= upd_flag_reg;
        end
    end

    // parameter store
    always_ff @(posedge clk)
    begin
        if (cmd.param_wr)
            param_mem[slot_reg] <= value_reg;
        else if (cmd.upd_write)
            param_mem[slot_reg] <= p_new;
        if (cmd.upd_read)
            param_rd_reg <= param_mem[slot_reg];
    end

    // gradient magnitude sums
    assign sum_addr  = (cmd.upd_read || cmd.upd_write) ? slot_reg : sweep_reg;
    assign sum_we    = cmd.sweep_clr || (cmd.upd_write && win_active);
    assign sum_wdata = cmd.sweep_clr ? '0 : sum_new;

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_addr] <= sum_wdata;
        if (cmd.upd_read || cmd.rec_read)
            sum_rd_reg <= sum_mem[sum_addr];
    end

    // per-parameter scales
    assign scale_we    = cmd.scale_one_wr || cmd.scale_sat_wr || cmd.scale_quo_wr;
    assign scale_wdata = cmd.scale_one_wr ? sgse_pkg::Q_ONE :
                         (cmd.scale_sat_wr ? sgse_pkg::SAT_POS : quo_sat);

    always_ff @(posedge clk)
    begin
        if (scale_we)
            scale_mem[sweep_reg] <= scale_wdata;
        if (cmd.upd_read)
            scale_rd_reg <= scale_mem[slot_reg];
    end

    always_comb
    begin
        status.func       = func_reg;
        status.stage_open = stage_open_reg;
        status.rows_zero  = (rows_eff == '0);
        status.sched_adv  = ((pos_x + 1'b1) < rows_eff)
                          && (thr_now[DW-1] || (stage_count_reg > thr_now));
        status.every_zero = (every_reg == '0);
        status.div_done   = div_done && !div_busy;
        status.rem_zero   = (div_rem == '0);
        status.win_active = win_active;
        status.win_last   = (window_left_reg == (DW + 1)'(1));
        status.stage_end  = ((CW'(index_reg) + 1'b1) >= cnt_eff);
        status.eps_neg    = eps_reg[DW-1];
        status.den_zero   = (recip_den == '0);
        status.sweep_last = (sweep_reg == LAST_A);
    end

    assign out_index_pad  = DW'(out_index_reg);
    assign out_index      = out_index_pad[IW-1:0];
    assign param_value    = out_pval_reg;
    assign rate_now       = out_rate_reg;
    assign stage_done     = out_done_reg;
    assign scales_updated = out_upd_reg;

endmodule

>>> tb/sgse_step_checker.sv
// Checker for the scaled gradient step engine: watches the ports, predicts each step and compares.
`timescale 1ns / 1ps
module sgse_step_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sgse_pkg::CFG_W-1:0]         cfg_index,
    input  logic [sgse_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [sgse_pkg::INDEX_W-1:0]       index,
    input  logic [sgse_pkg::DATA_W-1:0]        value,
    input  logic [sgse_pkg::DATA_W-1:0]        factor,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [sgse_pkg::INDEX_W-1:0]       out_index,
    input  logic [sgse_pkg::DATA_W-1:0]        param_value,
    input  logic [sgse_pkg::DATA_W-1:0]        rate_now,
    input  logic                               stage_done,
    input  logic                               scales_updated,
    output int                                 errors,
    output int                                 pending
);
    localparam int N_PARAMS = 1024;
    localparam int N_ROWS   = 8;

    typedef struct {
        logic [sgse_pkg::INDEX_W-1:0] idx;
        logic [sgse_pkg::DATA_W-1:0]  pval;
        logic [sgse_pkg::DATA_W-1:0]  rate;
        logic                         done;
        logic                         upd;
    } step_result_t;

    step_result_t step_results_due[$];

    logic [31:0] start_rate, decay_k, eval_every, eval_during, eps_off;
    logic [10:0] pcount;
    logic [3:0]  sched_rows;

    logic [31:0] params   [N_PARAMS];
    logic [47:0] grad_sums[N_PARAMS];
    logic [31:0] scales   [N_PARAMS];
    logic [31:0] thr      [N_ROWS];
    logic [31:0] fac      [N_ROWS];
    logic [31:0] stage_cnt;
    longint      win_left;
    int          sched_pos;
    logic [31:0] cur_rate;
    logic        stage_live;

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^16), saturated to signed 32 bits
    function automatic longint q16_mul(longint a, longint b);
        logic        neg;
        logic [63:0] ma, mb, prod, q;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = ma * mb;
        if (!neg)
        begin
            q = prod >> 16;
            return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
        end
        q = (prod + 64'd65535) >> 16;
        return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
    endfunction

    task automatic open_stage_pred();
        int          rows;
        logic [63:0] r, den;
        rows = (sched_rows < N_ROWS) ? sched_rows : N_ROWS;
        if (rows > 0)
        begin
            if (sched_pos >= rows) sched_pos = 0;
            while (sched_pos + 1 < rows &&
                   $signed({32'd0, stage_cnt}) > $signed({{32{thr[sched_pos][31]}}, thr[sched_pos]}))
                sched_pos++;
            r = (64'(start_rate) * 64'(fac[sched_pos])) >> 16;
            cur_rate = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        end
        else
        begin
            den = 64'd65536 + 64'(decay_k) * 64'(stage_cnt);
            r = (64'(start_rate) << 16) / den;
            cur_rate = r[31:0];
        end
        if (eval_every != 0 && (stage_cnt % eval_every) == 0)
        begin
            win_left = longint'(eval_during);
            foreach (grad_sums[k]) grad_sums[k] = '0;
        end
        stage_live = 1'b1;
    endtask

    task automatic rebuild_scales();
        logic [63:0] den, q;
        foreach (scales[k])
        begin
            if (eps_off[31])
                scales[k] = sgse_pkg::Q_ONE;
            else
            begin
                den = 64'(grad_sums[k]) / 64'(eval_during) + 64'(eps_off);
                q = (den == 0) ? 64'h7FFF_FFFF : (64'd1 << 32) / den;
                scales[k] = (q > 64'h7FFF_FFFF) ? sgse_pkg::SAT_POS : q[31:0];
            end
        end
    endtask

    task automatic predict_step(input logic [1:0] f, input logic [9:0] idx,
                                input logic [31:0] v, input logic [31:0] fa);
        step_result_t res;
        int           cnt;
        longint       g, t, u, p;
        logic [63:0]  s;
        res.idx  = idx;
        res.pval = '0;
        res.done = 1'b0;
        res.upd  = 1'b0;
        case (f)
            sgse_pkg::FUNC_NONE: return;
            sgse_pkg::FUNC_LOAD_PARAM:
            begin
                params[idx] = v;
                res.pval = v;
            end
            sgse_pkg::FUNC_LOAD_SCHED:
            begin
                if (idx < N_ROWS)
                begin
                    thr[idx] = v;
                    fac[idx] = fa;
                end
                sched_pos = 0;
            end
            default:
            begin
                g   = longint'($signed(v));
                cnt = pcount;
                if (cnt < 1) cnt = 1;
                if (cnt > N_PARAMS) cnt = N_PARAMS;
                if (!stage_live) open_stage_pred();
                t = q16_mul(longint'(cur_rate), g);
                u = q16_mul(t, longint'(scales[idx]));
                p = sat_s32(longint'($signed(params[idx])) - u);
                params[idx] = p[31:0];
                res.pval = params[idx];
                if (win_left > 0)
                begin
                    s = 64'(grad_sums[idx]) + 64'((g < 0) ? -g : g);
                    grad_sums[idx] = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
                end
                if (int'(idx) + 1 >= cnt)
                begin
                    res.done = 1'b1;
                    if (win_left > 0)
                    begin
                        win_left--;
                        if (win_left == 0)
                        begin
                            rebuild_scales();
                            res.upd = 1'b1;
                        end
                    end
                    stage_cnt++;
                    stage_live = 1'b0;
                end
            end
        endcase
        res.rate = cur_rate;
        step_results_due.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rate  = 32'd655;
            decay_k     = '0;
            eval_every  = 32'd1000;
            eval_during = 32'd1000;
            eps_off     = 32'd1;
            pcount      = 11'd1024;
            sched_rows  = '0;
            foreach (params[k]) params[k] = '0;
            foreach (grad_sums[k]) grad_sums[k] = '0;
            foreach (scales[k]) scales[k] = '0;
            foreach (thr[k]) thr[k] = '0;
            foreach (fac[k]) fac[k] = '0;
            stage_cnt  = '0;
            win_left   = -1;
            sched_pos  = 0;
            cur_rate   = '0;
            stage_live = 1'b0;
            errors     = 0;
            pending    = 0;
            step_results_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sgse_pkg::CFG_START_RATE:      start_rate  = cfg_data;
                    sgse_pkg::CFG_DECAY_CONSTANT:  decay_k     = cfg_data;
                    sgse_pkg::CFG_EVALUATE_EVERY:  eval_every  = cfg_data;
                    sgse_pkg::CFG_EVALUATE_DURING: eval_during = cfg_data;
                    sgse_pkg::CFG_EPSILON_OFFSET:  eps_off     = cfg_data;
                    sgse_pkg::CFG_PARAM_COUNT:     pcount      = cfg_data[10:0];
                    sgse_pkg::CFG_SCHEDULE_ROWS:
                    begin
                        sched_rows = cfg_data[3:0];
                        sched_pos  = 0;
                    end
                    default: ;
                endcase
            end
            // retire the oldest expectation against the beat leaving the block
            if (out_valid && out_ready)
            begin
                if (step_results_due.size() == 0)
                    report_mismatch("unexpected result beat, index", 32'(out_index), '0);
                else
                begin
                    step_result_t want;
                    want = step_results_due.pop_front();
                    if (out_index !== want.idx) report_mismatch("out_index", 32'(out_index), 32'(want.idx));
                    if (param_value !== want.pval) report_mismatch("param_value", param_value, want.pval);
                    if (rate_now !== want.rate) report_mismatch("rate_now", rate_now, want.rate);
                    if (stage_done !== want.done) report_mismatch("stage_done", 32'(stage_done), 32'(want.done));
                    if (scales_updated !== want.upd)
                        report_mismatch("scales_updated", 32'(scales_updated), 32'(want.upd));
                end
            end
            if (in_valid && in_ready)
                predict_step(func, index, value, factor);
            pending = step_results_due.size();
        end
    end
endmodule

>>> tb/scaled_gradient_step_engine_tb.sv
// Testbench top for the scaled gradient step engine: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module scaled_gradient_step_engine_tb;

    localparam int  N_PARAMS    = 1024;
    localparam int  CYCLE_LIMIT = 6000000;
    // idle cycles waited after the last result before the next phase
    localparam int  SETTLE      = 200;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write;
    logic [sgse_pkg::CFG_W-1:0]   cfg_index;
    logic [sgse_pkg::DATA_W-1:0]  cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   func;
    logic [sgse_pkg::INDEX_W-1:0] index;
    logic [sgse_pkg::DATA_W-1:0]  value;
    logic [sgse_pkg::DATA_W-1:0]  factor;
    logic                         out_valid;
    logic                         out_ready;
    logic [sgse_pkg::INDEX_W-1:0] out_index;
    logic [sgse_pkg::DATA_W-1:0]  param_value;
    logic [sgse_pkg::DATA_W-1:0]  rate_now;
    logic                         stage_done;
    logic                         scales_updated;
    int                           errors;
    int                           pending;

    // stimulus-side bookkeeping
    logic               param_loaded[N_PARAMS];
    int                 live_count;   // param_count as the block clamps it
    logic               calm;         // no idling on either side
    logic               hold_req;     // ask the receiver for one long hold-off
    longint             cycles;

    scaled_gradient_step_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .index         (index),
        .value         (value),
        .factor        (factor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_index     (out_index),
        .param_value   (param_value),
        .rate_now      (rate_now),
        .stage_done    (stage_done),
        .scales_updated(scales_updated)
    );

    sgse_step_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .index         (index),
        .value         (value),
        .factor        (factor),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_index     (out_index),
        .param_value   (param_value),
        .rate_now      (rate_now),
        .stage_done    (stage_done),
        .scales_updated(scales_updated),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: end the run if the block hangs
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("scaled_gradient_step_engine_tb failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    // No negedge carries more than one assignment to out_ready.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req  = 1'b0;
                out_ready = 1'b1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // write one register; the block must be idle
    task automatic write_reg(input logic [sgse_pkg::CFG_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == sgse_pkg::CFG_PARAM_COUNT)
        begin
            live_count = data[10:0];
            if (live_count < 1) live_count = 1;
            if (live_count > N_PARAMS) live_count = N_PARAMS;
        end
    endtask

    // offer one beat, with an optional gap first; hold valid until accepted,
    // then drop it so the beat is not offered twice
    task automatic send_beat(input logic [1:0] f, input logic [9:0] idx,
                             input logic [31:0] v, input logic [31:0] fa);
        @(negedge clk);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid = 1'b1;
        func     = f;
        index    = idx;
        value    = v;
        factor   = fa;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (f == sgse_pkg::FUNC_LOAD_PARAM) param_loaded[idx] = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // gradient on a parameter; load it first if it was never written
    task automatic send_gradient(input logic [9:0] idx, input logic [31:0] g);
        if (!param_loaded[idx]) send_beat(sgse_pkg::FUNC_LOAD_PARAM, idx, $urandom, $urandom);
        send_beat(sgse_pkg::FUNC_GRADIENT, idx, g, $urandom);
    endtask

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
        endcase
    endfunction

    // wait for every expected result, then let the block settle
    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly gradients inside the stage, with stage ends, stray indices,
    // loads of both kinds and unused operations mixed in
    task automatic random_beats(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 58)
                send_gradient(10'($urandom_range(0, live_count - 1)), pick_gradient());
            else if (r < 70)
                send_gradient(10'(live_count - 1), pick_gradient());
            else if (r < 75)
                send_gradient(10'($urandom), pick_gradient());
            else if (r < 87)
                send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'($urandom_range(0, live_count + 2)),
                          $urandom, $urandom);
            else if (r < 90)
                send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'($urandom), $urandom, $urandom);
            else if (r < 95)
                send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'($urandom_range(0, 11)),
                          $urandom_range(0, 40), $urandom_range(0, 32'h3_0000));
            else
                send_beat(sgse_pkg::FUNC_NONE, 10'($urandom), $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = sgse_pkg::FUNC_NONE;
        index     = '0;
        value     = '0;
        factor    = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        live_count = N_PARAMS;
        foreach (param_loaded[k]) param_loaded[k] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset settings, short stages
        write_reg(sgse_pkg::CFG_PARAM_COUNT, 32'd4);
        // fill every schedule row so no stage reads an empty one
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd0, 32'h8000_0000, 32'h0000_0000);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd1, 32'd0,         32'hFFFF_FFFF);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd2, 32'd2,         32'h0001_0000);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd3, 32'd4,         32'h0000_8000);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd4, 32'd7,         32'h0000_0001);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd5, 32'd12,        $urandom);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd6, 32'd20,        $urandom);
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd7, 32'h7FFF_FFFF, $urandom);
        // rows past the table are ignored but still answered
        send_beat(sgse_pkg::FUNC_LOAD_SCHED, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'd0, 32'h7FFF_FFFF, '0);
        send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'd1, 32'h8000_0000, '0);
        send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'd2, 32'h0000_0000, '0);
        send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'd3, 32'hFFFF_FFFF, '0);
        send_beat(sgse_pkg::FUNC_LOAD_PARAM, 10'd1023, 32'h0001_2345, '0);
        send_beat(sgse_pkg::FUNC_NONE, 10'd5, 32'h1234_5678, '0);
        send_gradient(10'd0, 32'h7FFF_FFFF);
        send_gradient(10'd1, 32'h8000_0000);
        // index beyond the count ends the stage
        send_gradient(10'd1023, 32'hFFFF_FFFF);
        send_gradient(10'd2, 32'h0000_0000);
        send_gradient(10'd3, 32'h0000_0001);
        send_gradient(10'd0, 32'h0001_0000);
        send_gradient(10'd3, 32'hFFFF_0000);
        drain();

        // schedule in force, clamped row count, saturating rate,
        // negative epsilon so scales go to one
        write_reg(sgse_pkg::CFG_START_RATE,      32'hFFFF_FFFF);
        write_reg(sgse_pkg::CFG_SCHEDULE_ROWS,   32'd15);
        write_reg(sgse_pkg::CFG_EVALUATE_EVERY,  32'd3);
        write_reg(sgse_pkg::CFG_EVALUATE_DURING, 32'd2);
        write_reg(sgse_pkg::CFG_EPSILON_OFFSET,  32'h8000_0000);
        write_reg(sgse_pkg::CFG_PARAM_COUNT,     32'd5);
        random_beats(170);
        // long receiver hold-off while beats keep coming: the block backs up
        hold_req = 1'b1;
        random_beats(180);
        drain();

        // decay formula, zero epsilon (zero divisor case), one-stage windows
        write_reg(sgse_pkg::CFG_SCHEDULE_ROWS,   32'd0);
        write_reg(sgse_pkg::CFG_START_RATE,      $urandom_range(32'h100, 32'h4_0000));
        write_reg(sgse_pkg::CFG_DECAY_CONSTANT,  $urandom_range(0, 32'h2000));
        write_reg(sgse_pkg::CFG_EPSILON_OFFSET,  32'd0);
        write_reg(sgse_pkg::CFG_EVALUATE_EVERY,  32'd50);
        write_reg(sgse_pkg::CFG_EVALUATE_DURING, 32'd1);
        write_reg(sgse_pkg::CFG_PARAM_COUNT,     32'd6);
        random_beats(150);
        // sender pauses until every result is back
        drain();
        random_beats(150);
        drain();

        // no windows, zero rate, largest decay and count above the store
        write_reg(sgse_pkg::CFG_START_RATE,      32'd0);
        write_reg(sgse_pkg::CFG_DECAY_CONSTANT,  32'hFFFF_FFFF);
        write_reg(sgse_pkg::CFG_EVALUATE_EVERY,  32'd0);
        write_reg(sgse_pkg::CFG_EVALUATE_DURING, 32'hFFFF_FFFF);
        write_reg(sgse_pkg::CFG_EPSILON_OFFSET,  32'h7FFF_FFFF);
        write_reg(sgse_pkg::CFG_PARAM_COUNT,     32'd2047);
        random_beats(200);
        drain();

        // window opening every stage but never closing; zero count clamps to one
        write_reg(sgse_pkg::CFG_SCHEDULE_ROWS,   32'd3);
        write_reg(sgse_pkg::CFG_START_RATE,      32'h0001_0000);
        write_reg(sgse_pkg::CFG_EVALUATE_EVERY,  32'd1);
        write_reg(sgse_pkg::CFG_EVALUATE_DURING, 32'd0);
        write_reg(sgse_pkg::CFG_PARAM_COUNT,     32'd0);
        random_beats(150);
        drain();

        // last part: positive epsilon, real scales, no idling at all
        calm = 1'b1;
        write_reg(sgse_pkg::CFG_SCHEDULE_ROWS,   32'd0);
        write_reg(sgse_pkg::CFG_START_RATE,      $urandom_range(32'h100, 32'h2_0000));
        write_reg(sgse_pkg::CFG_DECAY_CONSTANT,  32'd0);
        write_reg(sgse_pkg::CFG_EVALUATE_EVERY,  32'd40);
        write_reg(sgse_pkg::CFG_EVALUATE_DURING, 32'd3);
        write_reg(sgse_pkg::CFG_EPSILON_OFFSET,  $urandom_range(1, 32'h2_0000));
        write_reg(sgse_pkg::CFG_PARAM_COUNT,     32'd12);
        random_beats(380);
        @(negedge clk);
        in_valid = 1'b0;
        drain();

        if (errors == 0 && pending == 0)
            $display("scaled_gradient_step_engine_tb passed");
        else
        begin
            if (pending != 0) $display("%0d expected results never arrived", pending);
            $display("scaled_gradient_step_engine_tb failed");
        end
        $finish;
    end
endmodule

>>> files.f
sv/sgse_pkg.sv
sv/sgse_div.sv
sv/sgse_ctrl.sv
sv/sgse_dpath.sv
sv/scaled_gradient_step_engine.sv
tb/sgse_step_checker.sv
tb/scaled_gradient_step_engine_tb.sv
